[hw/rtl/iteration_gradient_color_map_defines.svh]
// Assertion macros for the iteration gradient color map.
// No dependencies; include by bare file name from files that assert.
`ifndef ITERATION_GRADIENT_COLOR_MAP_DEFINES_SVH
`define ITERATION_GRADIENT_COLOR_MAP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IGCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("igcm assertion failed");

// Next-cycle implication, disabled in reset.
`define IGCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("igcm assertion failed");

`endif

[hw/rtl/igcm_pkg.sv]
// Shared types and constants for the iteration gradient color map.
// No dependencies.
package igcm_pkg;

   localparam int ITER_WIDTH      = 16;
   localparam int SLOPE_FRAC_BITS = 16;
   localparam int CHAN_WIDTH      = 8;
   localparam int COLOR_WIDTH     = 3 * CHAN_WIDTH;
   localparam int NUM_CHAN        = 3;
   localparam int RANGE_WIDTH     = ITER_WIDTH - 2;
   localparam int QUO_WIDTH       = CHAN_WIDTH + SLOPE_FRAC_BITS;
   localparam int SLOPE_WIDTH     = QUO_WIDTH + 1;
   localparam int BITS_PER_STAGE  = 3;
   localparam int DIV_STAGES      = (QUO_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int FRAC_WIDTH      = 8;

   typedef enum logic [2:0] {
      CSR_MAX_ITER,
      CSR_SMOOTH_ENABLE,
      CSR_INTERIOR_COLOR,
      CSR_STOP_COLOR_0,
      CSR_STOP_COLOR_1,
      CSR_STOP_COLOR_2,
      CSR_STOP_COLOR_3,
      CSR_STOP_COLOR_4
   } csr_index_type;

   typedef struct packed {
      logic [ITER_WIDTH-1:0] iteration_count;
      logic [FRAC_WIDTH-1:0] smooth_fraction;
   } req_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } rsp_type;

endpackage

[hw/rtl/igcm_divider.sv]
// Pipelined restoring divider: sign-magnitude stop difference scaled by
// 2^SLOPE_FRAC_BITS over the segment range. Depends on igcm_pkg.
module igcm_divider
   import igcm_pkg::*;
(
   input  logic                          clock,
   input  logic                          advance,
   input  logic [CHAN_WIDTH-1:0]         mag,
   input  logic                          neg,
   input  logic [RANGE_WIDTH-1:0]        divisor,
   output logic signed [SLOPE_WIDTH-1:0] slope
);

   logic [RANGE_WIDTH-1:0] rem_ff [DIV_STAGES];
   logic [RANGE_WIDTH-1:0] rem_in [DIV_STAGES];
   logic [QUO_WIDTH-1:0]   quo_ff [DIV_STAGES];
   logic [QUO_WIDTH-1:0]   quo_in [DIV_STAGES];
   logic [CHAN_WIDTH-1:0]  mag_ff [DIV_STAGES];
   logic                   neg_ff [DIV_STAGES];
   logic [RANGE_WIDTH-1:0] div_ff [DIV_STAGES];

   // Three quotient bits per stage; each stage reads only its predecessor.
   always_comb begin
      logic [RANGE_WIDTH-1:0] r;
      logic [QUO_WIDTH-1:0]   q;
      logic [RANGE_WIDTH:0]   trial;
      logic [QUO_WIDTH-1:0]   dvd;
      logic [RANGE_WIDTH-1:0] d;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            r   = '0;
            q   = '0;
            dvd = {mag, {SLOPE_FRAC_BITS{1'b0}}};
            d   = divisor;
         end else begin
            r   = rem_ff[s-1];
            q   = quo_ff[s-1];
            dvd = {mag_ff[s-1], {SLOPE_FRAC_BITS{1'b0}}};
            d   = div_ff[s-1];
         end
         for (int k = 0; k < BITS_PER_STAGE; k++) begin
            if (s * BITS_PER_STAGE + k < QUO_WIDTH) begin
               trial = {r, dvd[QUO_WIDTH-1-(s*BITS_PER_STAGE+k)]};
               if (trial >= {1'b0, d}) begin
                  trial = trial - {1'b0, d};
                  q     = {q[QUO_WIDTH-2:0], 1'b1};
               end else begin
                  q     = {q[QUO_WIDTH-2:0], 1'b0};
               end
               r = trial[RANGE_WIDTH-1:0];
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            if (s == 0) begin
               mag_ff[s] <= mag;
               neg_ff[s] <= neg;
               div_ff[s] <= divisor;
            end else begin
               mag_ff[s] <= mag_ff[s-1];
               neg_ff[s] <= neg_ff[s-1];
               div_ff[s] <= div_ff[s-1];
            end
         end
      end
   end

   // Zero range gives a flat slope.
   always_comb begin
      if (div_ff[DIV_STAGES-1] == '0) begin
         slope = '0;
      end else if (neg_ff[DIV_STAGES-1]) begin
         slope = -$signed({1'b0, quo_ff[DIV_STAGES-1]});
      end else begin
         slope = $signed({1'b0, quo_ff[DIV_STAGES-1]});
      end
   end

endmodule

[hw/rtl/iteration_gradient_color_map.sv]
// Top level of the iteration gradient color map: segment select, slope
// divider pipeline, interpolation and clamp. Depends on igcm_pkg,
// igcm_divider and iteration_gradient_color_map_defines.svh.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type (count, fraction)
//   rsp      out        rsp_valid/rsp_stall  rsp_type (red, green, blue)
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One pixel per clock while the result is not stalled. Results pass the prep
// register, DIV_STAGES divider stages of three quotient bits, multiply and output.
// Synchronous active-high reset clears valid bits and loads register defaults.
// A stalled result freezes the whole pipeline, so no transfer is lost or
// repeated; bubbles travel with the data.
`include "iteration_gradient_color_map_defines.svh"

module iteration_gradient_color_map
   import igcm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [COLOR_WIDTH-1:0] csr_data
);

   typedef struct packed {
      logic                                 interior;
      logic [NUM_CHAN-1:0][CHAN_WIDTH-1:0]  lo;
      logic [ITER_WIDTH-1:0]                offset;
      logic [FRAC_WIDTH-1:0]                frac;
   } side_type;

   // Configuration registers
   logic [ITER_WIDTH-1:0]  max_iter_ff;
   logic                   smooth_ff;
   logic [COLOR_WIDTH-1:0] interior_ff;
   logic [COLOR_WIDTH-1:0] stop0_ff, stop1_ff, stop2_ff, stop3_ff, stop4_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ITER_WIDTH'(100);
         smooth_ff   <= 1'b0;
         interior_ff <= '0;
         stop0_ff    <= '0;
         stop1_ff    <= '0;
         stop2_ff    <= '0;
         stop3_ff    <= '0;
         stop4_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_ITER:       max_iter_ff <= csr_data[ITER_WIDTH-1:0];
            CSR_SMOOTH_ENABLE:  smooth_ff   <= csr_data[0];
            CSR_INTERIOR_COLOR: interior_ff <= csr_data;
            CSR_STOP_COLOR_0:   stop0_ff    <= csr_data;
            CSR_STOP_COLOR_1:   stop1_ff    <= csr_data;
            CSR_STOP_COLOR_2:   stop2_ff    <= csr_data;
            CSR_STOP_COLOR_3:   stop3_ff    <= csr_data;
            CSR_STOP_COLOR_4:   stop4_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Whole pipeline moves together unless the result register is blocked.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;

   // Stage 1: segment select, range, offset, stop difference
   logic [ITER_WIDTH+1:0]  n4, m1, m2, m3, segm;
   logic signed [ITER_WIDTH+2:0] t_val;
   logic [1:0]             seg;
   logic [COLOR_WIDTH-1:0] lo_col, hi_col;
   side_type               prep_in;
   logic [RANGE_WIDTH-1:0] range_in;
   logic [ITER_WIDTH-1:0]  m_minus4;
   logic [NUM_CHAN-1:0][CHAN_WIDTH-1:0] mag_in;
   logic [NUM_CHAN-1:0]    neg_in;

   always_comb begin
      logic signed [CHAN_WIDTH:0] diff;
      n4 = {req_data.iteration_count, 2'b00};
      m1 = {2'b00, max_iter_ff};
      m2 = {1'b0, max_iter_ff, 1'b0};
      m3 = m1 + m2;
      if (n4 <= m1) begin
         seg  = 2'd0;
         segm = '0;
      end else if (n4 <= m2) begin
         seg  = 2'd1;
         segm = m1;
      end else if (n4 <= m3) begin
         seg  = 2'd2;
         segm = m2;
      end else begin
         seg  = 2'd3;
         segm = m3;
      end
      t_val = $signed({1'b0, n4}) - $signed({1'b0, segm}) - (ITER_WIDTH+3)'(4);

      case (seg)
         2'd0:    begin lo_col = stop0_ff; hi_col = stop1_ff; end
         2'd1:    begin lo_col = stop1_ff; hi_col = stop2_ff; end
         2'd2:    begin lo_col = stop2_ff; hi_col = stop3_ff; end
         default: begin lo_col = stop3_ff; hi_col = stop4_ff; end
      endcase

      m_minus4 = max_iter_ff - ITER_WIDTH'(4);
      if (seg != 2'd3) begin
         range_in = max_iter_ff[ITER_WIDTH-1:2];
      end else if (max_iter_ff >= ITER_WIDTH'(4)) begin
         range_in = m_minus4[ITER_WIDTH-1:2];
      end else begin
         range_in = '0;
      end

      prep_in.interior = req_data.iteration_count >= max_iter_ff;
      prep_in.frac     = req_data.smooth_fraction;
      if (seg == 2'd0) begin
         prep_in.offset = req_data.iteration_count;
      end else if (t_val < 0) begin
         prep_in.offset = '0;
      end else begin
         prep_in.offset = t_val[ITER_WIDTH+1:2];
      end

      // Channel 0 is red, taken from the top byte.
      for (int c = 0; c < NUM_CHAN; c++) begin
         prep_in.lo[c] = lo_col[COLOR_WIDTH-1-c*CHAN_WIDTH -: CHAN_WIDTH];
         diff = $signed({1'b0, hi_col[COLOR_WIDTH-1-c*CHAN_WIDTH -: CHAN_WIDTH]})
              - $signed({1'b0, prep_in.lo[c]});
         neg_in[c] = diff[CHAN_WIDTH];
         mag_in[c] = neg_in[c] ? CHAN_WIDTH'(-diff) : diff[CHAN_WIDTH-1:0];
      end
   end

   logic                                prep_valid_ff;
   side_type                            prep_ff;
   logic [RANGE_WIDTH-1:0]              range_ff;
   logic [NUM_CHAN-1:0][CHAN_WIDTH-1:0] mag_ff;
   logic [NUM_CHAN-1:0]                 neg_ff;

   // Divider stages: sideband rides a matching delay line.
   logic                          div_valid_ff [DIV_STAGES];
   side_type                      side_ff [DIV_STAGES];
   logic signed [SLOPE_WIDTH-1:0] slope [NUM_CHAN];

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_div
      igcm_divider u_div (
         .clock   (clock),
         .advance (advance),
         .mag     (mag_ff[c]),
         .neg     (neg_ff[c]),
         .divisor (range_ff),
         .slope   (slope[c])
      );
   end

   // Multiply stage
   localparam int PROD_WIDTH  = ITER_WIDTH + 1 + SLOPE_WIDTH;
   localparam int SPROD_WIDTH = FRAC_WIDTH + 1 + SLOPE_WIDTH;
   localparam int VAL_WIDTH   = PROD_WIDTH + 2;

   logic                          mul_valid_ff;
   logic                          mul_interior_ff;
   logic [CHAN_WIDTH-1:0]         mul_lo_ff    [NUM_CHAN];
   logic signed [PROD_WIDTH-1:0]  prod_ff      [NUM_CHAN];
   logic signed [SPROD_WIDTH-1:0] sprod_ff     [NUM_CHAN];
   logic signed [SLOPE_WIDTH-1:0] mul_slope_ff [NUM_CHAN];

   // Output stage: extra slope (scaled by the fraction in smooth mode), sum, truncate and clamp
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      logic signed [SPROD_WIDTH-1:0] biased;
      logic signed [SPROD_WIDTH-1:0] scaled;
      logic signed [VAL_WIDTH-1:0]   value;
      logic signed [VAL_WIDTH-1:0]   whole;
      logic [NUM_CHAN-1:0][CHAN_WIDTH-1:0] chan;
      for (int c = 0; c < NUM_CHAN; c++) begin
         // Round toward zero when scaling by the Q0.8 fraction.
         biased = sprod_ff[c] + ((sprod_ff[c] < 0) ? SPROD_WIDTH'(255) : SPROD_WIDTH'(0));
         scaled = biased >>> FRAC_WIDTH;
         value  = $signed({{(VAL_WIDTH-CHAN_WIDTH-SLOPE_FRAC_BITS){1'b0}}, mul_lo_ff[c],
                           {SLOPE_FRAC_BITS{1'b0}}})
                + VAL_WIDTH'(prod_ff[c])
                + (smooth_ff ? VAL_WIDTH'(scaled) : VAL_WIDTH'(mul_slope_ff[c]));
         whole  = value >>> SLOPE_FRAC_BITS;
         if (value < 0) begin
            chan[c] = '0;
         end else if (whole > VAL_WIDTH'(255)) begin
            chan[c] = '1;
         end else begin
            chan[c] = whole[CHAN_WIDTH-1:0];
         end
      end
      if (mul_interior_ff) begin
         rsp_in = interior_ff;
      end else begin
         rsp_in.red   = chan[0];
         rsp_in.green = chan[1];
         rsp_in.blue  = chan[2];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
         for (int s = 0; s < DIV_STAGES; s++) begin
            div_valid_ff[s] <= 1'b0;
         end
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= req_valid;
         for (int s = 0; s < DIV_STAGES; s++) begin
            div_valid_ff[s] <= (s == 0) ? prep_valid_ff : div_valid_ff[s-1];
         end
         mul_valid_ff <= div_valid_ff[DIV_STAGES-1];
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   // Payload: hold on stall, advance otherwise
   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff  <= prep_in;
         range_ff <= range_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         for (int s = 0; s < DIV_STAGES; s++) begin
            side_ff[s] <= (s == 0) ? prep_ff : side_ff[s-1];
         end
         mul_interior_ff <= side_ff[DIV_STAGES-1].interior;
         for (int c = 0; c < NUM_CHAN; c++) begin
            mul_lo_ff[c]    <= side_ff[DIV_STAGES-1].lo[c];
            mul_slope_ff[c] <= slope[c];
            prod_ff[c]      <= $signed({1'b0, side_ff[DIV_STAGES-1].offset}) * slope[c];
            sprod_ff[c]     <= slope[c] * $signed({1'b0, side_ff[DIV_STAGES-1].frac});
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   `IGCM_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)
   `IGCM_ASSERT_NEXT(a_mul_to_rsp, clock, reset, mul_valid_ff && advance, rsp_valid_ff)
   `IGCM_ASSERT_NEXT(a_prep_to_div, clock, reset, prep_valid_ff && advance, div_valid_ff[0])

endmodule
